[hdl/hpfc_pkg.sv]
`timescale 1ns / 1ps

package hpfc_pkg;

    // Packed widths of the stream words.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int TX_W      = 40;

    // Received frame bytes that take part in decoding (slots 0 to 4).
    localparam int FRAME_BYTES = 5;
    localparam logic [2:0] SLOT_LAST = 3'd5;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef enum logic [1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_BUTTON  = 2'd1,
        CMD_ROTARY  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        BTN_AUTO        = 3'd0,
        BTN_MODE        = 3'd1,
        BTN_AC          = 3'd2,
        BTN_FRONT_DEMIST = 3'd3,
        BTN_REAR_DEMIST = 3'd4,
        BTN_AIR_SOURCE  = 3'd5,
        BTN_OFF         = 3'd6,
        BTN_NONE        = 3'd7
    } button_t;

    // Frame header bytes.
    localparam logic [7:0] HDR_NORMAL  = 8'h0D;
    localparam logic [7:0] HDR_AMBIENT = 8'h0E;
    localparam logic [7:0] HDR_STOPPED = 8'h0F;

    localparam logic [2:0] FAN_CODE_OFF = 3'd7;

    // Transmit byte values.
    localparam logic [7:0] TX_IDLE      = 8'h80;
    localparam logic [7:0] TX_B4_BASE   = 8'hFC;
    localparam logic [7:0] TX_AUTO_B1   = 8'h82;
    localparam logic [7:0] TX_AUTO_B4   = 8'hFA;
    localparam logic [7:0] TX_MODE_B1   = 8'h90;
    localparam logic [7:0] TX_MODE_B4   = 8'hEC;
    localparam logic [7:0] TX_AC_B1     = 8'h84;
    localparam logic [7:0] TX_AC_B4     = 8'hF8;
    localparam logic [7:0] TX_FDM_B1    = 8'hA0;
    localparam logic [7:0] TX_FDM_B4    = 8'hDC;
    localparam logic [7:0] TX_RDM_B1    = 8'hC0;
    localparam logic [7:0] TX_RDM_B4    = 8'hBC;
    localparam logic [7:0] TX_SRC_B1    = 8'h88;
    localparam logic [7:0] TX_SRC_B4    = 8'hF4;
    localparam logic [7:0] TX_OFF_B1    = 8'h81;
    localparam logic [7:0] TX_OFF_B4    = 8'hFB;
    localparam logic [7:0] TX_OFF_B3    = 8'h90;
    localparam logic [7:0] TX_OFF_B4_IDLE = 8'hEC;
    localparam logic [7:0] TX_AMB_B2    = 8'hA0;
    localparam logic [7:0] TX_AMB_B4    = 8'hDC;
    localparam logic [7:0] TX_FAN_UP_B3 = 8'h90;
    localparam logic [7:0] TX_FAN_UP_B4 = 8'hEC;
    localparam logic [7:0] TX_FAN_DN_B3 = 8'hF0;
    localparam logic [7:0] TX_FAN_DN_B4 = 8'h8C;
    localparam logic [7:0] TX_TMP_UP_B3 = 8'h81;
    localparam logic [7:0] TX_TMP_UP_B4 = 8'hFB;
    localparam logic [7:0] TX_TMP_DN_B3 = 8'h87;
    localparam logic [7:0] TX_TMP_DN_B4 = 8'hF5;

    typedef struct packed {
        logic        running;
        logic        ambient;
        logic [2:0]  fan;
        logic [11:0] digits;
        logic [2:0]  cooling;
        logic [4:0]  airflow;
    } indicators_t;

endpackage

[hdl/hpfc_frame_decode.sv]
`timescale 1ns / 1ps

// Decodes a completed receive frame into the panel indicator set and
// reports whether any indicator differs from the previous set.
module hpfc_frame_decode
(
    input  hpfc_pkg::frame_t      frame,
    input  hpfc_pkg::indicators_t old_ind,
    output hpfc_pkg::indicators_t new_ind,
    output logic                  changed
);
    import hpfc_pkg::*;

    logic [2:0] fan_code;
    logic [7:0] b4;
    logic       fd;
    logic       feet;
    logic       face;

    assign fan_code = frame[2][6:4];
    assign b4       = frame[4];

    always_comb
    begin
        // Front demist, feet and face hold when the code matches no pattern.
        fd   = old_ind.airflow[0];
        feet = old_ind.airflow[1];
        face = old_ind.airflow[2];
        if (b4[0] && b4[1])
        begin
            fd = 1'b0; feet = 1'b1; face = 1'b0;
        end
        else if (b4[0])
        begin
            if (!b4[2] && b4[6])
            begin
                fd = 1'b1; feet = 1'b1; face = 1'b0;
            end
            else if (b4[2])
            begin
                fd = 1'b1; feet = 1'b0; face = 1'b0;
            end
        end
        else if (!b4[1])
        begin
            fd = 1'b0; feet = 1'b0; face = 1'b1;
        end
        else
        begin
            fd = 1'b0; feet = 1'b1; face = 1'b1;
        end

        new_ind.running = (fan_code != FAN_CODE_OFF);
        new_ind.ambient = (frame[0] == HDR_AMBIENT);
        new_ind.fan     = (fan_code == FAN_CODE_OFF) ? 3'd0 : fan_code + 3'd1;
        new_ind.digits  = {frame[3][3:0], frame[2][3:0], frame[1][3:0]};
        new_ind.cooling = ~{frame[3][6], frame[3][5], frame[3][4]};
        new_ind.airflow = {b4[3], ~b4[5], face, feet, fd};
    end

    assign changed = (new_ind != old_ind);

endmodule

[hdl/hvac_panel_frame_codec.sv]
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: rx_byte, button_code, fan_step, temp_step;
//                      tuser: command
// m_axis    out        tdata: display_changed, link_active, amp_running,
//                      ambient_shown, fan_level, temp_nibbles, cooling_flags,
//                      airflow_flags, tx_frame; tlast: frame_done
// cfg       in         data: tx_default_frame (byte 0 in the top bits)
//
// Every input word produces exactly one output word, loaded into the result
// register at the edge that accepts it; the block sustains one word per clock
// while m_axis is ready. The panel state is held in registers that update at
// the same accepting edge. s_tready stays high while the result register is
// empty or is being drained, so a stall on m_axis holds one result and then
// back-pressures s_axis. rst_n clears the state and m_tvalid asynchronously,
// not m_tdata or m_tlast. The config port is always ready and reloads tx_frame.
module hvac_panel_frame_codec
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Input: [7:0] rx_byte, [10:8] button_code, [12:11] fan_step,
    // [14:13] temp_step, [15] zero.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hpfc_pkg::S_TDATA_W-1:0] s_tdata,
    // Command: [1:0] command.
    input  logic [hpfc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Result: [0] display_changed, [1] link_active, [2] amp_running,
    // [3] ambient_shown, [6:4] fan_level, [18:7] temp_nibbles,
    // [21:19] cooling_flags, [26:22] airflow_flags, [66:27] tx_frame,
    // [71:67] zero.
    output logic [hpfc_pkg::M_TDATA_W-1:0] m_tdata,
    // Frame done.
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hpfc_pkg::TX_W-1:0]      cfg_data
);
    import hpfc_pkg::*;

    frame_t                 frame_reg;
    frame_t                 frame_next;
    logic [2:0]             slot_reg;
    logic [2:0]             slot_next;
    logic [2:0]             slot_inc;
    logic                   link_reg;
    logic                   link_next;
    indicators_t            ind_reg;
    indicators_t            ind_next;
    logic                   changed_reg;
    logic                   changed_next;
    logic                   amb_before_off_reg;
    logic                   amb_before_off_next;
    logic                   skip_rotary_reg;
    logic                   skip_rotary_next;
    logic [TX_W-1:0]        tx_reg;
    logic [TX_W-1:0]        tx_next;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TDATA_W-1:0]   m_tdata_next;
    logic                   m_tlast_reg;
    logic                   frame_done;

    indicators_t            dec_ind;
    logic                   dec_changed;

    logic                   accept;
    cmd_t                   cmd;
    logic [7:0]             rx_byte;
    button_t                button;
    logic [1:0]             fan_step;
    logic [1:0]             temp_step;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cmd       = cmd_t'(s_tuser);
    assign rx_byte   = s_tdata[7:0];
    assign button    = button_t'(s_tdata[10:8]);
    assign fan_step  = s_tdata[12:11];
    assign temp_step = s_tdata[14:13];
    assign slot_inc  = slot_reg + 3'd1;

    hpfc_frame_decode u_decode
    (
        .frame   (frame_reg),
        .old_ind (ind_reg),
        .new_ind (dec_ind),
        .changed (dec_changed)
    );

    always_comb
    begin
        frame_next          = frame_reg;
        slot_next           = slot_reg;
        link_next           = link_reg;
        ind_next            = ind_reg;
        changed_next        = changed_reg;
        amb_before_off_next = amb_before_off_reg;
        skip_rotary_next    = skip_rotary_reg;
        tx_next             = tx_reg;
        frame_done          = 1'b0;

        case (cmd)
            CMD_RX_BYTE:
            begin
                link_next = 1'b1;
                if (rx_byte == HDR_NORMAL || rx_byte == HDR_AMBIENT ||
                    rx_byte == HDR_STOPPED)
                begin
                    slot_next    = 3'd0;
                    frame_next[0] = rx_byte;
                end
                else if (slot_inc == SLOT_LAST)
                begin
                    // The closing byte itself is not used by the decode.
                    frame_done   = 1'b1;
                    ind_next     = dec_ind;
                    changed_next = dec_changed;
                    slot_next    = 3'd0;
                end
                else
                begin
                    slot_next = slot_inc;
                    for (int i = 1; i < FRAME_BYTES; i++)
                    begin
                        if (slot_inc == 3'(i))
                            frame_next[i] = rx_byte;
                    end
                end
            end

            CMD_BUTTON:
            begin
                tx_next[23:16] = TX_IDLE;
                tx_next[7:0]   = TX_B4_BASE;
                case (button)
                    BTN_AUTO:
                    begin
                        tx_next[31:24] = TX_AUTO_B1;
                        tx_next[7:0]   = TX_AUTO_B4;
                    end
                    BTN_MODE:
                    begin
                        tx_next[31:24] = TX_MODE_B1;
                        tx_next[7:0]   = TX_MODE_B4;
                    end
                    BTN_AC:
                    begin
                        tx_next[31:24] = TX_AC_B1;
                        tx_next[7:0]   = TX_AC_B4;
                    end
                    BTN_FRONT_DEMIST:
                    begin
                        tx_next[31:24] = TX_FDM_B1;
                        tx_next[7:0]   = TX_FDM_B4;
                    end
                    BTN_REAR_DEMIST:
                    begin
                        tx_next[31:24] = TX_RDM_B1;
                        tx_next[7:0]   = TX_RDM_B4;
                    end
                    BTN_AIR_SOURCE:
                    begin
                        tx_next[31:24] = TX_SRC_B1;
                        tx_next[7:0]   = TX_SRC_B4;
                    end
                    BTN_OFF:
                    begin
                        if (ind_reg.running)
                        begin
                            tx_next[31:24]      = TX_OFF_B1;
                            tx_next[7:0]        = TX_OFF_B4;
                            amb_before_off_next = ind_reg.ambient;
                        end
                        else
                        begin
                            // With the amplifier stopped, off drops an ambient
                            // display that was not on before the unit went off,
                            // and the next knob event is swallowed.
                            tx_next[15:8] = TX_OFF_B3;
                            tx_next[7:0]  = TX_OFF_B4_IDLE;
                            if (ind_reg.ambient && !amb_before_off_reg)
                            begin
                                ind_next.ambient = 1'b0;
                                tx_next[23:16]   = TX_AMB_B2;
                                tx_next[7:0]     = TX_AMB_B4;
                            end
                            skip_rotary_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        tx_next[31:24] = TX_IDLE;
                    end
                endcase
            end

            CMD_ROTARY:
            begin
                if (skip_rotary_reg)
                begin
                    skip_rotary_next = 1'b0;
                end
                else
                begin
                    // The reserved step pattern counts as a step down.
                    tx_next[15:8] = TX_IDLE;
                    if (fan_step == 2'b01)
                    begin
                        tx_next[15:8] = TX_FAN_UP_B3;
                        tx_next[7:0]  = TX_FAN_UP_B4;
                    end
                    else if (fan_step[1])
                    begin
                        tx_next[15:8] = TX_FAN_DN_B3;
                        tx_next[7:0]  = TX_FAN_DN_B4;
                    end
                    if (temp_step == 2'b01)
                    begin
                        tx_next[15:8] = TX_TMP_UP_B3;
                        tx_next[7:0]  = TX_TMP_UP_B4;
                    end
                    else if (temp_step[1])
                    begin
                        tx_next[15:8] = TX_TMP_DN_B3;
                        tx_next[7:0]  = TX_TMP_DN_B4;
                    end
                end
            end

            default:
            begin
                // The unused command leaves every state register unchanged.
            end
        endcase

        m_tdata_next = {5'd0, tx_next, ind_next.airflow, ind_next.cooling,
                        ind_next.digits, ind_next.fan, ind_next.ambient,
                        ind_next.running, link_next, changed_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg          <= '0;
            slot_reg           <= 3'd0;
            link_reg           <= 1'b0;
            ind_reg            <= '0;
            changed_reg        <= 1'b0;
            amb_before_off_reg <= 1'b0;
            skip_rotary_reg    <= 1'b0;
        end
        else if (accept)
        begin
            frame_reg          <= frame_next;
            slot_reg           <= slot_next;
            link_reg           <= link_next;
            ind_reg            <= ind_next;
            changed_reg        <= changed_next;
            amb_before_off_reg <= amb_before_off_next;
            skip_rotary_reg    <= skip_rotary_next;
        end
    end

    // A configuration write reloads the transmit frame with the defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tx_reg <= '0;
        else if (cfg_valid)
            tx_reg <= cfg_data;
        else if (accept)
            tx_reg <= tx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= frame_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[hdl/hpfc_checker.sv]
`timescale 1ns / 1ps

module hpfc_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hpfc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import hpfc_pkg::*;

    // Every accepted word yields a result word on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

    // An empty result register never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled while result register empty");

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

    // A completed frame implies the link has seen bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[1])
    else $error("frame done without link activity");

    // After a decode, the running flag agrees with a nonzero fan level.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[2] == (m_tdata[6:4] != 3'd0))
    else $error("running flag disagrees with fan level");

endmodule

bind hvac_panel_frame_codec hpfc_checker u_hpfc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/hvac_panel_frame_codec_tb.sv]
`timescale 1ns / 1ps

module hvac_panel_frame_codec_tb;
    import hpfc_pkg::*;

    // The fourth command code is unused by the block: it must leave all state alone
    // and still return one word.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Knob step encodings. The wrap pattern reads as -2 and therefore acts as a step down.
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_WRAP = 2'b10;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    localparam logic [TX_W-1:0] TX_ALL_ONES = '1;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_REPORTS      = 10;

    // One input word, lowest field in the lowest bits, topped up with a zero bit.
    typedef struct packed {
        logic       pad;
        logic [1:0] temp_step;
        logic [1:0] fan_step;
        logic [2:0] button_code;
        logic [7:0] rx_byte;
    } panel_fields_t;

    // One result word as it leaves on m_tdata.
    typedef struct packed {
        logic [4:0]      pad;
        logic [TX_W-1:0] tx_frame;
        logic [4:0]      airflow;
        logic [2:0]      cooling;
        logic [11:0]     digits;
        logic [2:0]      fan;
        logic            ambient;
        logic            running;
        logic            link_active;
        logic            display_changed;
    } result_word_t;

    typedef struct {
        result_word_t word;
        logic         frame_done;
    } expected_report_t;

    // Tracks the panel state alongside the block, works out the report that every
    // accepted word must produce, and compares the reports that come back in order.
    class panel_scoreboard;
        logic [7:0]       rx_frame [0:5];
        logic [2:0]       slot;
        logic             link_seen;
        indicators_t      shown;
        logic             changed;
        logic             ambient_at_off;
        logic             skip_armed;
        logic [TX_W-1:0]  tx_bytes;
        expected_report_t expected_reports [$];
        int unsigned      words_in;
        int unsigned      frames_done;
        int unsigned      buttons;
        int unsigned      rotaries;
        int unsigned      swallowed;
        int unsigned      checked;
        int unsigned      cfg_writes;
        int unsigned      errors;

        function new();
            foreach (rx_frame[i])
                rx_frame[i] = 8'h00;
            slot           = '0;
            link_seen      = 1'b0;
            shown          = '0;
            changed        = 1'b0;
            ambient_at_off = 1'b0;
            skip_armed     = 1'b0;
            tx_bytes       = '0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Transmit byte 0 sits in the top bits, byte 4 in the bottom bits.
        function void set_tx(int k, logic [7:0] v);
            tx_bytes[(4 - k) * 8 +: 8] = v;
        endfunction

        function void load_default(logic [TX_W-1:0] v);
            tx_bytes = v;
            cfg_writes++;
        endfunction

        function void flag(string what, logic [TX_W-1:0] want, logic [TX_W-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        endfunction

        function void compare_field(string what, logic [TX_W-1:0] want, logic [TX_W-1:0] got);
            if (got !== want)
                flag(what, want, got);
        endfunction

        function void predict_word(logic [1:0] cmd, logic [S_TDATA_W-1:0] data);
            panel_fields_t    f;
            indicators_t      prev;
            logic [7:0]       b4;
            logic [2:0]       code;
            logic             fd;
            logic             feet;
            logic             face;
            button_t          btn;
            expected_report_t e;
            logic             done;

            f    = data;
            done = 1'b0;
            words_in++;
            case (cmd)
                CMD_RX_BYTE:
                begin
                    link_seen = 1'b1;
                    if (f.rx_byte == HDR_NORMAL || f.rx_byte == HDR_AMBIENT ||
                        f.rx_byte == HDR_STOPPED)
                    begin
                        // Any header restarts the frame, whatever slot was pending.
                        slot        = '0;
                        rx_frame[0] = f.rx_byte;
                    end
                    else
                    begin
                        if (slot < SLOT_LAST)
                            slot = slot + 3'd1;
                        rx_frame[slot] = f.rx_byte;
                        if (slot == SLOT_LAST)
                        begin
                            prev = shown;
                            b4   = rx_frame[4];
                            // The stopped header clears running, but the fan code
                            // below always has the final word on it.
                            if (rx_frame[0] == HDR_STOPPED)
                                shown.running = 1'b0;
                            shown.ambient = (rx_frame[0] == HDR_AMBIENT);
                            shown.cooling = ~{rx_frame[3][6], rx_frame[3][5],
                                              rx_frame[3][4]};
                            code = rx_frame[2][6:4];
                            if (code != FAN_CODE_OFF)
                            begin
                                shown.fan     = code + 3'd1;
                                shown.running = 1'b1;
                            end
                            else
                            begin
                                shown.fan     = 3'd0;
                                shown.running = 1'b0;
                            end
                            // A demist bit with no matching mode keeps the old vents.
                            fd   = shown.airflow[0];
                            feet = shown.airflow[1];
                            face = shown.airflow[2];
                            if (b4[0] && b4[1])
                            begin
                                fd = 1'b0; feet = 1'b1; face = 1'b0;
                            end
                            else if (b4[0])
                            begin
                                if (!b4[2] && b4[6])
                                begin
                                    fd = 1'b1; feet = 1'b1; face = 1'b0;
                                end
                                else if (b4[2])
                                begin
                                    fd = 1'b1; feet = 1'b0; face = 1'b0;
                                end
                            end
                            else if (!b4[1])
                            begin
                                fd = 1'b0; feet = 1'b0; face = 1'b1;
                            end
                            else
                            begin
                                fd = 1'b0; feet = 1'b1; face = 1'b1;
                            end
                            shown.airflow = {b4[3], ~b4[5], face, feet, fd};
                            shown.digits  = {rx_frame[3][3:0], rx_frame[2][3:0],
                                             rx_frame[1][3:0]};
                            changed = (shown != prev);
                            slot    = '0;
                            done    = 1'b1;
                            frames_done++;
                        end
                    end
                end
                CMD_BUTTON:
                begin
                    buttons++;
                    btn = button_t'(f.button_code);
                    set_tx(2, TX_IDLE);
                    set_tx(4, TX_B4_BASE);
                    case (btn)
                        BTN_AUTO:
                        begin
                            set_tx(1, TX_AUTO_B1); set_tx(4, TX_AUTO_B4);
                        end
                        BTN_MODE:
                        begin
                            set_tx(1, TX_MODE_B1); set_tx(4, TX_MODE_B4);
                        end
                        BTN_AC:
                        begin
                            set_tx(1, TX_AC_B1); set_tx(4, TX_AC_B4);
                        end
                        BTN_FRONT_DEMIST:
                        begin
                            set_tx(1, TX_FDM_B1); set_tx(4, TX_FDM_B4);
                        end
                        BTN_REAR_DEMIST:
                        begin
                            set_tx(1, TX_RDM_B1); set_tx(4, TX_RDM_B4);
                        end
                        BTN_AIR_SOURCE:
                        begin
                            set_tx(1, TX_SRC_B1); set_tx(4, TX_SRC_B4);
                        end
                        BTN_OFF:
                        begin
                            if (shown.running)
                            begin
                                set_tx(1, TX_OFF_B1);
                                set_tx(4, TX_OFF_B4);
                                ambient_at_off = shown.ambient;
                            end
                            else
                            begin
                                set_tx(3, TX_OFF_B3);
                                set_tx(4, TX_OFF_B4_IDLE);
                                if (shown.ambient && !ambient_at_off)
                                begin
                                    shown.ambient = 1'b0;
                                    set_tx(2, TX_AMB_B2);
                                    set_tx(4, TX_AMB_B4);
                                end
                                skip_armed = 1'b1;
                            end
                        end
                        default: set_tx(1, TX_IDLE);
                    endcase
                end
                CMD_ROTARY:
                begin
                    rotaries++;
                    if (skip_armed)
                    begin
                        // The first knob turn after an off while stopped is dropped whole.
                        skip_armed = 1'b0;
                        swallowed++;
                    end
                    else
                    begin
                        set_tx(3, TX_IDLE);
                        if (f.fan_step == STEP_UP)
                        begin
                            set_tx(3, TX_FAN_UP_B3); set_tx(4, TX_FAN_UP_B4);
                        end
                        else if (f.fan_step == STEP_DOWN || f.fan_step == STEP_WRAP)
                        begin
                            set_tx(3, TX_FAN_DN_B3); set_tx(4, TX_FAN_DN_B4);
                        end
                        if (f.temp_step == STEP_UP)
                        begin
                            set_tx(3, TX_TMP_UP_B3); set_tx(4, TX_TMP_UP_B4);
                        end
                        else if (f.temp_step == STEP_DOWN || f.temp_step == STEP_WRAP)
                        begin
                            set_tx(3, TX_TMP_DN_B3); set_tx(4, TX_TMP_DN_B4);
                        end
                    end
                end
                default: ;
            endcase

            e.frame_done           = done;
            e.word                 = '0;
            e.word.display_changed = changed;
            e.word.link_active     = link_seen;
            e.word.running         = shown.running;
            e.word.ambient         = shown.ambient;
            e.word.fan             = shown.fan;
            e.word.digits          = shown.digits;
            e.word.cooling         = shown.cooling;
            e.word.airflow         = shown.airflow;
            e.word.tx_frame        = tx_bytes;
            expected_reports.push_back(e);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] data, logic last);
            expected_report_t want;
            result_word_t     got;

            if (expected_reports.size() == 0)
            begin
                flag("result word with nothing outstanding", '0, data[TX_W-1:0]);
                return;
            end
            want = expected_reports.pop_front();
            got  = data;
            checked++;
            compare_field("frame_done", want.frame_done, last);
            compare_field("display_changed", want.word.display_changed, got.display_changed);
            compare_field("link_active", want.word.link_active, got.link_active);
            compare_field("amp_running", want.word.running, got.running);
            compare_field("ambient_shown", want.word.ambient, got.ambient);
            compare_field("fan_level", want.word.fan, got.fan);
            compare_field("temp_nibbles", want.word.digits, got.digits);
            compare_field("cooling_flags", want.word.cooling, got.cooling);
            compare_field("airflow_flags", want.word.airflow, got.airflow);
            compare_field("tx_frame", want.word.tx_frame, got.tx_frame);
            compare_field("tdata padding", want.word.pad, got.pad);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TX_W-1:0]      cfg_data;

    panel_scoreboard sb;

    // Set by the stimulus to ask the result side for one long hold-off.
    bit          hold_request;
    // When clear, the sender offers words back to back with no gaps.
    bit          pacing_on;
    int          burst_left;
    int unsigned items_sent;

    hvac_panel_frame_codec u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample every handshake at the edge on which it completes. A result at this
    // edge always belongs to a word accepted at an earlier edge, so it is checked
    // before the word accepted now is added to the expected reports.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.predict_word(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                sb.load_default(cfg_data);
        end
    end

    // Result side: picks a new stall pattern whenever the current one runs out, from
    // always ready to mostly stalled, and serves one long hold-off when asked.
    initial
    begin : result_sink
        int hold_left;
        int pattern_left;
        int sink_mode;
        int tick;

        hold_left    = 0;
        pattern_left = 0;
        sink_mode    = 0;
        tick         = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    sink_mode    = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 96);
                end
                else
                    pattern_left--;
                case (sink_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 4) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic panel_fields_t fresh_fields();
        panel_fields_t f;

        f     = 16'($urandom);
        f.pad = 1'b0;
        return f;
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;

        do
            b = 8'($urandom);
        while (b == HDR_NORMAL || b == HDR_AMBIENT || b == HDR_STOPPED);
        return b;
    endfunction

    function automatic logic [7:0] header_byte();
        case ($urandom_range(0, 2))
            0: return HDR_NORMAL;
            1: return HDR_AMBIENT;
            default: return HDR_STOPPED;
        endcase
    endfunction

    // Offer one word and hold it until accepted. Between bursts of random length
    // the sender drops tvalid for a random gap; some gaps are zero, which gives
    // long stretches of back-to-back words.
    task automatic send_item(input logic [1:0] cmd, input panel_fields_t f);
        int gap;

        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= f;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (pacing_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // The unused fields of every word carry random bits, so each input bit but the
    // zero pad bit toggles regardless of the command mix.
    task automatic send_rx(input logic [7:0] b);
        panel_fields_t f;

        f         = fresh_fields();
        f.rx_byte = b;
        send_item(CMD_RX_BYTE, f);
    endtask

    task automatic send_button(input logic [2:0] code);
        panel_fields_t f;

        f             = fresh_fields();
        f.button_code = code;
        send_item(CMD_BUTTON, f);
    endtask

    task automatic send_rotary(input logic [1:0] fan, input logic [1:0] temp);
        panel_fields_t f;

        f           = fresh_fields();
        f.fan_step  = fan;
        f.temp_step = temp;
        send_item(CMD_ROTARY, f);
    endtask

    // A frame body of body_len bytes, optionally after a header. A full body is
    // five bytes; shorter ones leave the frame open for whatever comes next.
    // Now and then a button press lands in the middle of the frame.
    task automatic send_frame(input bit with_header, input int body_len);
        int         k;
        logic [7:0] b;

        if (with_header)
            send_rx(header_byte());
        for (k = 1; k <= body_len; k++)
        begin
            b = payload_byte();
            if (k == 2 && $urandom_range(0, 3) == 0)
                b[6:4] = FAN_CODE_OFF;
            if ($urandom_range(0, 15) == 0)
                send_button(3'($urandom));
            send_rx(b);
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int          pick;

        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_frame($urandom_range(0, 6) != 0, 5);
            else if (pick < 55)
                send_frame(1'b1, $urandom_range(1, 4));
            else if (pick < 70)
                send_button(($urandom_range(0, 3) == 0) ? BTN_OFF : 3'($urandom));
            else if (pick < 82)
                send_rotary(2'($urandom), 2'($urandom));
            else if (pick < 88)
            begin
                send_button(BTN_OFF);
                send_rotary(2'($urandom), 2'($urandom));
            end
            else if (pick < 94)
                send_rx(8'($urandom));
            else
                send_item(CMD_SPARE, fresh_fields());
        end
    endtask

    // Stop offering and wait until every expected report has come back. The
    // condition is read at the falling edge, after the monitor has run.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_default(input logic [TX_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [TX_W-1:0] dflt;

        sb           = new();
        hold_request = 1'b0;
        pacing_on    = 1'b1;
        burst_left   = 0;
        items_sent   = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_default('0);

        // Spare command straight out of reset, every field bit set.
        send_item(CMD_SPARE, 16'h7FFF);
        // Stopped header but a valid fan code: running must still come up.
        send_rx(HDR_STOPPED);
        send_rx(8'h00);
        send_rx(8'h35);
        send_rx(8'h70);
        send_rx(8'h43);
        send_rx(8'hFF);
        // Ambient header with the fan off, and a demist bit with no matching mode.
        send_rx(HDR_AMBIENT);
        send_rx(8'h09);
        send_rx(8'hFA);
        send_rx(8'h8F);
        send_rx(8'h01);
        send_rx(8'h00);
        // Off while stopped with ambient shown: ambient flips, next knob is dropped.
        send_button(BTN_OFF);
        send_rotary(STEP_UP, STEP_UP);
        send_rotary(STEP_DOWN, STEP_WRAP);
        send_rotary(STEP_WRAP, STEP_UP);
        // Headerless frame reusing the stored header, top fan code.
        send_rx(8'h12);
        send_rx(8'h65);
        send_rx(8'h00);
        send_rx(8'h41);
        send_rx(8'h20);
        send_button(BTN_OFF);
        send_button(BTN_AUTO);
        send_button(BTN_MODE);
        send_button(BTN_AC);
        send_button(BTN_FRONT_DEMIST);
        send_button(BTN_REAR_DEMIST);
        send_button(BTN_AIR_SOURCE);
        send_button(BTN_NONE);
        wait_drained();

        write_default(TX_ALL_ONES);
        run_random(230);
        wait_drained();

        // Hold the result side off while words keep coming with no gaps, so the
        // block fills up and has to stall its input.
        dflt = {8'($urandom), 32'($urandom)};
        write_default(dflt);
        hold_request = 1'b1;
        pacing_on    = 1'b0;
        run_random(40);
        pacing_on    = 1'b1;
        run_random(190);
        wait_drained();

        dflt = {8'($urandom), 32'($urandom)};
        write_default(dflt);
        run_random(240);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d words: %0d decoded frames, %0d button presses,",
                 sb.words_in, sb.frames_done, sb.buttons);
        $display("%0d knob turns (%0d dropped after off), default frame written %0d times.",
                 sb.rotaries, sb.swallowed, sb.cfg_writes);
        $display("%0d results checked, %0d errors, %0d still owed.",
                 sb.checked, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hdl/hpfc_pkg.sv
hdl/hpfc_frame_decode.sv
hdl/hvac_panel_frame_codec.sv
hdl/hpfc_checker.sv
tb/hvac_panel_frame_codec_tb.sv
